/* src/ising_wolff_cluster_flip_macros.svh */
// Assertion macros shared by the Wolff cluster block checkers.
// Depends on nothing; included by the checker file.
`ifndef ISING_WOLFF_CLUSTER_FLIP_MACROS_SVH
`define ISING_WOLFF_CLUSTER_FLIP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IWC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define IWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/iwc_pkg.sv */
// Shared types, constants and functions of the Wolff cluster update block.
// No dependencies; imported by the controller, datapath and top level.
package iwc_pkg;

    // Field and register widths
    localparam int SEED_SITE_W    = 14;
    localparam int CLUSTER_SIZE_W = 15;
    localparam int MAGNET_W       = 16;
    localparam int THRESH_W       = 16;
    localparam int PRNG_W         = 32;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 32;

    // Defaults
    localparam int                  SIDE_DEFAULT   = 128;
    localparam logic [THRESH_W-1:0] THRESH_DEFAULT = 16'd28670;
    localparam logic [PRNG_W-1:0]   SEED_DEFAULT   = 32'd2463534242;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BOND_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANDOM_SEED    = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_RD,
        ST_NB_CHK,
        ST_DONE
    } t_state;

    // Neighbor visiting order
    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DN,
        DIR_LF,
        DIR_RT
    } t_dir;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;       // clearing pass: write spin up, advance address
        logic seed_load;    // take the seed site from the input
        logic reduce_step;  // subtract one row from the seed remainder
        logic red_fin;      // remainder is the column
        logic seed_rd;      // read the seed spin
        logic seed_commit;  // flip seed, queue it, restart the FIFO
        logic pop_rd;       // read FIFO head
        logic cur_load;     // FIFO data becomes the current member
        logic nb_rd;        // read the next neighbor spin
        logic nb_chk;       // test neighbor, draw, maybe join
        logic finish;       // update magnetization, load the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic rem_ge;
        logic fifo_empty;
        logic nb_last;
        logic out_busy;
    } t_stat;

    // One xorshift32 step
    function automatic logic [PRNG_W-1:0] f_xorshift32(input logic [PRNG_W-1:0] s);
        logic [PRNG_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

/* src/iwc_ctrl.sv */
// Controller state machine of the Wolff cluster update block.
// Depends on iwc_pkg; drives iwc_dpath through t_cmd and reads t_stat.
module iwc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iwc_pkg::t_stat i_stat,
    output iwc_pkg::t_cmd  o_cmd
);
    import iwc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_REDUCE;
            ST_REDUCE:   if (!i_stat.rem_ge) n_state = ST_SEED_RD;
            ST_SEED_RD:  n_state = ST_SEED_WR;
            ST_SEED_WR:  n_state = ST_POP;
            ST_POP:      n_state = i_stat.fifo_empty ? ST_DONE : ST_POP_WAIT;
            ST_POP_WAIT: n_state = ST_NB_RD;
            ST_NB_RD:    n_state = ST_NB_CHK;
            ST_NB_CHK:   n_state = i_stat.nb_last ? ST_POP : ST_NB_RD;
            ST_DONE:     if (!i_stat.out_busy) n_state = ST_IDLE;
            default:     n_state = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.seed_load = i_in_valid;
            end
            ST_REDUCE: begin
                o_cmd.reduce_step = i_stat.rem_ge;
                o_cmd.red_fin     = !i_stat.rem_ge;
            end
            ST_SEED_RD:  o_cmd.seed_rd = 1'b1;
            ST_SEED_WR:  o_cmd.seed_commit = 1'b1;
            ST_POP:      o_cmd.pop_rd = !i_stat.fifo_empty;
            ST_POP_WAIT: o_cmd.cur_load = 1'b1;
            ST_NB_RD:    o_cmd.nb_rd = 1'b1;
            ST_NB_CHK:   o_cmd.nb_chk = 1'b1;
            ST_DONE:     o_cmd.finish = !i_stat.out_busy;
            default:     o_cmd = '0;
        endcase
    end

endmodule

/* src/iwc_dpath.sv */
// Datapath of the Wolff cluster update block: lattice and FIFO memories,
// xorshift32 generator, counters and result register. Depends on iwc_pkg.
module iwc_dpath #(
    parameter int SIDE = iwc_pkg::SIDE_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [iwc_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [iwc_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic [iwc_pkg::SEED_SITE_W-1:0]        i_seed_site,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [iwc_pkg::CLUSTER_SIZE_W-1:0]     o_cluster_size,
    output logic signed [iwc_pkg::MAGNET_W-1:0]    o_magnet_sum,
    input  iwc_pkg::t_cmd                          i_cmd,
    output iwc_pkg::t_stat                         o_stat
);
    import iwc_pkg::*;

    localparam int SITES = SIDE * SIDE;
    localparam int AW    = $clog2(SIDE);
    localparam int SAW   = $clog2(SITES);
    localparam int TW    = $clog2(SITES + 1);
    localparam logic [AW-1:0]          ROW_MAX  = AW'(SIDE - 1);
    localparam logic [SEED_SITE_W-1:0] SIDE_REM = SEED_SITE_W'(SIDE);

    // Site index of a row and column
    function automatic logic [SAW-1:0] f_site(input logic [AW-1:0] row,
                                              input logic [AW-1:0] col);
        return SAW'(32'(row) * 32'(SIDE) + 32'(col));
    endfunction

    // Storage
    logic              r_lattice [SITES];
    logic [2*AW-1:0]   r_frontier [SITES];

    logic [SAW-1:0]         r_clr;
    logic [SEED_SITE_W-1:0] r_rem;
    logic [AW-1:0]          r_cur_row, r_cur_col;
    logic [AW-1:0]          r_nb_row, r_nb_col;
    logic [AW-1:0]          n_nb_row, n_nb_col;
    t_dir                   r_dir;
    logic                   r_orig;
    logic                   r_lat_rd;
    logic [2*AW-1:0]        r_fr_rd;
    logic [TW-1:0]          r_head, r_tail;
    logic [PRNG_W-1:0]      r_prng;
    logic [THRESH_W-1:0]    r_thresh;
    logic [MAGNET_W-1:0]    r_magnet;
    logic [MAGNET_W-1:0]    n_magnet;
    logic [MAGNET_W-1:0]    twice_size;
    logic                   r_out_valid;
    logic [CLUSTER_SIZE_W-1:0] r_out_size;
    logic [MAGNET_W-1:0]    r_out_mag;

    logic [PRNG_W-1:0]   prng_next;
    logic                same_spin;
    logic                join_nb;
    logic [SAW-1:0]      cur_site, nb_site_r, nb_site_c;
    logic                lat_we, lat_wd, lat_re;
    logic [SAW-1:0]      lat_wa, lat_ra;
    logic                fr_we;
    logic [SAW-1:0]      fr_wa;
    logic [2*AW-1:0]     fr_wd;

    // Neighbor coordinates with toroidal wrap
    always_comb begin
        n_nb_row = r_cur_row;
        n_nb_col = r_cur_col;
        case (r_dir)
            DIR_UP:  n_nb_row = (r_cur_row == '0) ? ROW_MAX : r_cur_row - 1'b1;
            DIR_DN:  n_nb_row = (r_cur_row == ROW_MAX) ? '0 : r_cur_row + 1'b1;
            DIR_LF:  n_nb_col = (r_cur_col == '0) ? ROW_MAX : r_cur_col - 1'b1;
            DIR_RT:  n_nb_col = (r_cur_col == ROW_MAX) ? '0 : r_cur_col + 1'b1;
            default: n_nb_row = r_cur_row;
        endcase
    end

    // Bond test
    assign prng_next = f_xorshift32(r_prng);
    assign same_spin = (r_lat_rd == r_orig);
    assign join_nb   = i_cmd.nb_chk && same_spin && (prng_next[31:16] < r_thresh);

    // Lattice port addressing
    assign cur_site  = f_site(r_cur_row, r_cur_col);
    assign nb_site_r = f_site(r_nb_row, r_nb_col);
    assign nb_site_c = f_site(n_nb_row, n_nb_col);

    always_comb begin
        lat_we = i_cmd.clr_wr | i_cmd.seed_commit | join_nb;
        lat_wa = i_cmd.clr_wr ? r_clr : (i_cmd.seed_commit ? cur_site : nb_site_r);
        lat_wd = i_cmd.clr_wr ? 1'b1 : (i_cmd.seed_commit ? ~r_lat_rd : ~r_orig);
        lat_re = i_cmd.seed_rd | i_cmd.nb_rd;
        lat_ra = i_cmd.seed_rd ? cur_site : nb_site_c;
        fr_we  = i_cmd.seed_commit | join_nb;
        // seed always lands in the first FIFO slot
        fr_wa  = i_cmd.seed_commit ? '0 : r_tail[SAW-1:0];
        fr_wd  = i_cmd.seed_commit ? {r_cur_row, r_cur_col} : {r_nb_row, r_nb_col};
    end

    // Lattice memory
    always_ff @(posedge i_clk) begin
        if (lat_we) begin
            r_lattice[lat_wa] <= lat_wd;
        end
        if (lat_re) begin
            r_lat_rd <= r_lattice[lat_ra];
        end
    end

    // Frontier FIFO memory
    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            r_frontier[fr_wa] <= fr_wd;
        end
        if (i_cmd.pop_rd) begin
            r_fr_rd <= r_frontier[r_head[SAW-1:0]];
        end
    end

    // Site payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_rem     <= i_seed_site;
            r_cur_row <= '0;
        end else if (i_cmd.reduce_step) begin
            r_rem     <= r_rem - SIDE_REM;
            r_cur_row <= (r_cur_row == ROW_MAX) ? '0 : r_cur_row + 1'b1;
        end else if (i_cmd.cur_load) begin
            r_cur_row <= r_fr_rd[2*AW-1:AW];
        end
        if (i_cmd.red_fin) begin
            r_cur_col <= r_rem[AW-1:0];
        end else if (i_cmd.cur_load) begin
            r_cur_col <= r_fr_rd[AW-1:0];
        end
        if (i_cmd.nb_rd) begin
            r_nb_row <= n_nb_row;
            r_nb_col <= n_nb_col;
        end
        if (i_cmd.seed_commit) begin
            r_orig <= r_lat_rd;
        end
        if (i_cmd.finish) begin
            r_out_size <= CLUSTER_SIZE_W'(r_tail);
            r_out_mag  <= n_magnet;
        end
    end

    // Magnetization after this cluster
    assign twice_size = MAGNET_W'(32'(r_tail) << 1);
    assign n_magnet   = r_orig ? r_magnet - twice_size : r_magnet + twice_size;

    // Control registers: counters, generator, config, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_dir       <= DIR_UP;
            r_prng      <= SEED_DEFAULT;
            r_thresh    <= THRESH_DEFAULT;
            r_magnet    <= MAGNET_W'(SITES);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.seed_commit) begin
                r_head <= '0;
                r_tail <= TW'(1);
            end else begin
                if (i_cmd.pop_rd) r_head <= r_head + 1'b1;
                if (join_nb) r_tail <= r_tail + 1'b1;
            end
            if (i_cmd.cur_load) begin
                r_dir <= DIR_UP;
            end else if (i_cmd.nb_chk) begin
                r_dir <= t_dir'(r_dir + 1'b1);
            end
            // generator advances only on a checked neighbor with the seed's original spin
            if (i_cfg_wr_en && i_cfg_addr == CFG_RANDOM_SEED) begin
                r_prng <= (i_cfg_wdata == '0) ? SEED_DEFAULT : i_cfg_wdata;
            end else if (i_cmd.nb_chk && same_spin) begin
                r_prng <= prng_next;
            end
            if (i_cfg_wr_en && i_cfg_addr == CFG_BOND_THRESHOLD) begin
                r_thresh <= i_cfg_wdata[THRESH_W-1:0];
            end
            if (i_cmd.finish) begin
                r_magnet    <= n_magnet;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status
    always_comb begin
        o_stat.clr_last   = (r_clr == SAW'(SITES - 1));
        o_stat.rem_ge     = (r_rem >= SIDE_REM);
        o_stat.fifo_empty = (r_head == r_tail);
        o_stat.nb_last    = (r_dir == DIR_RT);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_cluster_size = r_out_size;
    assign o_magnet_sum   = r_out_mag;

endmodule

/* src/ising_wolff_cluster_flip.sv */
// Wolff cluster update on a SIDE x SIDE toroidal Ising lattice held in a
// one-bit-per-site memory. After reset the block runs a clearing pass over
// all SIDE*SIDE sites that sets every spin up; no seed is accepted until it ends
// (configuration writes are taken throughout). Each accepted seed site is first
// reduced to a row and column by one subtraction of SIDE per cycle, then the
// cluster grows breadth-first through an on-chip FIFO. The single lattice read
// port sets the pace: each cluster member takes a FIFO pop and wait, then a read
// and a test step for each of its four neighbors. The result (cluster size
// and magnetization sum) sits in an output register, and the next seed is taken
// while it waits.
module ising_wolff_cluster_flip #(
    parameter int SIDE = iwc_pkg::SIDE_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [iwc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [iwc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [iwc_pkg::SEED_SITE_W-1:0]     i_seed_site,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [iwc_pkg::CLUSTER_SIZE_W-1:0]  o_cluster_size,
    output logic signed [iwc_pkg::MAGNET_W-1:0] o_magnet_sum
);
    import iwc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    iwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Lattice, FIFO, generator and result
    iwc_dpath #(
        .SIDE (SIDE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_seed_site    (i_seed_site),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_cluster_size (o_cluster_size),
        .o_magnet_sum   (o_magnet_sum),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

/* src/iwc_checker.sv */
// Port-level checker for the Wolff cluster update block, bound to the top.
// Depends on iwc_pkg and ising_wolff_cluster_flip_macros.svh.
`include "ising_wolff_cluster_flip_macros.svh"

module iwc_checker #(
    parameter int SIDE = iwc_pkg::SIDE_DEFAULT
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [iwc_pkg::CLUSTER_SIZE_W-1:0]  o_cluster_size,
    input logic signed [iwc_pkg::MAGNET_W-1:0] o_magnet_sum
);
    import iwc_pkg::*;

    // A stalled result transaction holds its payload
    `IWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_cluster_size) && $stable(o_magnet_sum), "result changed while stalled")

    // Spins flip in pairs of magnetization steps, so the sum keeps the parity of the site count
    `IWC_ASSERT_SAME(a_mag_parity, i_clk, i_rst_n, o_out_valid, o_magnet_sum[0] == 1'(SIDE % 2), "magnetization parity broken")

    // A seed is never taken twice in a row: the cluster work follows
    `IWC_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready held after a seed transaction")

    // While idle no new result appears, so a taken result empties the output
    `IWC_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, o_out_valid && i_out_ready && o_in_ready, !o_out_valid, "result appeared without a cluster update")

endmodule

bind ising_wolff_cluster_flip iwc_checker #(.SIDE(SIDE)) u_iwc_checker (.*);
